>>> rtl/tfs_pkg.sv
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and constants for the textured fragment shader
// Block codes, texture slots, light direction and the command word that
// travels from the front end through the queue to the shading pipeline.
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam int TEX_SIDE_DEF = 16;
    localparam int TEX_COUNT    = 7;
    localparam int CMD_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    // texture slots
    localparam logic [2:0] SLOT_DIRT       = 3'd0;
    localparam logic [2:0] SLOT_STONE      = 3'd1;
    localparam logic [2:0] SLOT_GRASS_SIDE = 3'd2;
    localparam logic [2:0] SLOT_GRASS_TOP  = 3'd3;
    localparam logic [2:0] SLOT_LEAVES     = 3'd4;
    localparam logic [2:0] SLOT_LOG        = 3'd5;
    localparam logic [2:0] SLOT_LOG_TOP    = 3'd6;

    // block codes
    localparam logic [7:0] BLK_STONE  = 8'd1;
    localparam logic [7:0] BLK_DIRT   = 8'd2;
    localparam logic [7:0] BLK_GRASS  = 8'd3;
    localparam logic [7:0] BLK_LOG    = 8'd4;
    localparam logic [7:0] BLK_LEAVES = 8'd5;

    // faces that see the top or bottom texture
    localparam logic [2:0] FACE_NEG_Y = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;

    // light direction (1, 2.5, -1.5) normalized, Q.14
    localparam logic signed [15:0] LIGHT_X = 16'sd5316;
    localparam logic signed [15:0] LIGHT_Y = 16'sd13289;
    localparam logic signed [15:0] LIGHT_Z = -16'sd7974;

    localparam logic [13:0] SOFT_WEIGHT = 14'd9830;   // 0.15 in Q.16
    localparam logic [16:0] AMBIENT_Q16 = 17'd16384;  // 0.25
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [7:0]  OPAQUE      = 8'd255;

    // magenta for unknown blocks
    localparam logic [7:0] MAG_RED   = 8'd255;
    localparam logic [7:0] MAG_GREEN = 8'd0;
    localparam logic [7:0] MAG_BLUE  = 8'd255;

    typedef struct packed {
        logic               is_shade;
        logic               wr_en;
        logic               known;
        logic [31:0]        texel;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_cmd;

endpackage

>>> rtl/tfs_ram.sv
// ----------------------------------------------------------------------------
// tfs_ram: generic single-port RAM
// One address per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module tfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1792
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tfs_fifo.sv
// ----------------------------------------------------------------------------
// tfs_fifo: small register queue
// Push and pop in the same cycle are allowed; caller guards full and empty.
// ----------------------------------------------------------------------------
module tfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

>>> rtl/tfs_front.sv
// ----------------------------------------------------------------------------
// tfs_front: request classification
// Decodes loads and shades, picks the texture, wraps the coordinates and
// forms the texel store address for the command queue.
// ----------------------------------------------------------------------------
module tfs_front #(
    parameter int TEX_SIDE = tfs_pkg::TEX_SIDE_DEF
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [2:0]            i_tex_slot,
    input  logic [7:0]            i_texel_index,
    input  logic [31:0]           i_texel_value,
    input  logic [7:0]            i_block_code,
    input  logic [2:0]            i_face,
    input  logic signed [15:0]    i_tex_u,
    input  logic signed [15:0]    i_tex_v,
    input  logic signed [15:0]    i_normal_x,
    input  logic signed [15:0]    i_normal_y,
    input  logic signed [15:0]    i_normal_z,
    input  logic                  i_q_full,
    output logic                  o_push,
    output tfs_pkg::t_cmd         o_cmd,
    output logic [$clog2(tfs_pkg::TEX_COUNT * TEX_SIDE * TEX_SIDE)-1:0] o_addr
);

    localparam int TEXELS = TEX_SIDE * TEX_SIDE;
    localparam int ADDR_W = $clog2(tfs_pkg::TEX_COUNT * TEXELS);
    localparam int SIDE_W = $clog2(TEX_SIDE);
    localparam int MUL_W  = SIDE_W + 10;

    logic [2:0]        w_slot;
    logic              w_known;
    logic [MUL_W-1:0]  w_col_prod;
    logic [MUL_W-1:0]  w_row_prod;
    logic [SIDE_W-1:0] w_col;
    logic [SIDE_W:0]   w_row_full;
    logic [SIDE_W-1:0] w_row;
    logic [ADDR_W-1:0] w_load_addr;
    logic [ADDR_W-1:0] w_shade_addr;

    always_comb begin
        w_slot  = tfs_pkg::SLOT_DIRT;
        w_known = 1'b1;
        case (i_block_code)
            tfs_pkg::BLK_STONE:  w_slot = tfs_pkg::SLOT_STONE;
            tfs_pkg::BLK_DIRT:   w_slot = tfs_pkg::SLOT_DIRT;
            tfs_pkg::BLK_GRASS: begin
                if (i_face == tfs_pkg::FACE_NEG_Y) begin
                    w_slot = tfs_pkg::SLOT_DIRT;
                end else if (i_face == tfs_pkg::FACE_POS_Y) begin
                    w_slot = tfs_pkg::SLOT_GRASS_TOP;
                end else begin
                    w_slot = tfs_pkg::SLOT_GRASS_SIDE;
                end
            end
            tfs_pkg::BLK_LOG: begin
                if (i_face inside {tfs_pkg::FACE_NEG_Y, tfs_pkg::FACE_POS_Y}) begin
                    w_slot = tfs_pkg::SLOT_LOG_TOP;
                end else begin
                    w_slot = tfs_pkg::SLOT_LOG;
                end
            end
            tfs_pkg::BLK_LEAVES: w_slot = tfs_pkg::SLOT_LEAVES;
            default:             w_known = 1'b0;
        endcase
    end

    // fractional part of the coordinate, v flipped
    assign w_col_prod = MUL_W'(i_tex_u[7:0]) * MUL_W'(TEX_SIDE);
    assign w_row_prod = MUL_W'(9'd256 - {1'b0, i_tex_v[7:0]}) * MUL_W'(TEX_SIDE);
    assign w_col      = w_col_prod[SIDE_W+7:8];
    assign w_row_full = w_row_prod[SIDE_W+8:8];
    // zero v fraction lands one past the last row and wraps to the first
    assign w_row      = (w_row_full >= (SIDE_W + 1)'(TEX_SIDE)) ? '0 : w_row_full[SIDE_W-1:0];

    assign w_load_addr  = ADDR_W'(i_tex_slot) * ADDR_W'(TEXELS) + ADDR_W'(i_texel_index);
    assign w_shade_addr = ADDR_W'(w_slot) * ADDR_W'(TEXELS)
                        + ADDR_W'(w_row) * ADDR_W'(TEX_SIDE) + ADDR_W'(w_col);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.is_shade = (i_req_type == tfs_pkg::REQ_SHADE);
        o_cmd.wr_en    = (i_req_type == tfs_pkg::REQ_LOAD)
                      && (i_tex_slot < 3'(tfs_pkg::TEX_COUNT))
                      && (32'(i_texel_index) < 32'(TEXELS));
        o_cmd.known    = w_known;
        o_cmd.texel    = i_texel_value;
        o_cmd.nx       = i_normal_x;
        o_cmd.ny       = i_normal_y;
        o_cmd.nz       = i_normal_z;
    end

    assign o_addr = (i_req_type == tfs_pkg::REQ_SHADE) ? w_shade_addr : w_load_addr;

endmodule

>>> rtl/tfs_back.sv
// ----------------------------------------------------------------------------
// tfs_back: texel store and shading pipeline
// Issues one command per cycle while shades find output credit: loads write
// the store, shades read it and pass four stages into the output queue.
// ----------------------------------------------------------------------------
module tfs_back #(
    parameter int TEX_SIDE = tfs_pkg::TEX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  tfs_pkg::t_cmd         i_q_cmd,
    input  logic [$clog2(tfs_pkg::TEX_COUNT * TEX_SIDE * TEX_SIDE)-1:0] i_q_addr,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha
);

    localparam int STORE_DEPTH = tfs_pkg::TEX_COUNT * TEX_SIDE * TEX_SIDE;
    localparam int CRD_W       = $clog2(tfs_pkg::OUT_DEPTH + 1);

    // issue
    logic             w_issue_shade;
    logic             w_out_xfer;
    logic [CRD_W-1:0] r_credit, n_credit;
    logic [31:0]      w_rdata;

    // stage 1
    logic               r1_valid;
    logic               r1_known;
    logic signed [29:0] r1_px, r1_py, r1_pz;
    // stage 2
    logic               r2_valid;
    logic signed [30:0] r2_dot;
    logic [7:0]         r2_r, r2_g, r2_b;
    // stage 3
    logic               r3_valid;
    logic [16:0]        r3_s16;
    logic [30:0]        r3_wprod;
    logic [7:0]         r3_r, r3_g, r3_b;
    // stage 4
    logic               r4_valid;
    logic [24:0]        r4_pr, r4_pg, r4_pb;

    logic [29:0] w_mag;
    logic [28:0] w_clamp;
    logic [16:0] w_q16;
    logic [16:0] w_w16;
    logic [30:0] w_soft_sum;
    logic [17:0] w_fsum;
    logic [16:0] w_factor;
    logic [24:0] w_rr, w_rg, w_rb;
    logic [23:0] w_out_data;
    logic        w_out_empty;
    logic        w_out_full;

    // a shade needs a free output slot for when it arrives
    assign w_issue_shade = !i_q_empty && i_q_cmd.is_shade
                        && (r_credit < CRD_W'(tfs_pkg::OUT_DEPTH));
    assign o_q_pop       = !i_q_empty && (!i_q_cmd.is_shade || w_issue_shade);
    assign w_out_xfer    = o_valid && i_ready;

    always_comb begin
        n_credit = r_credit;
        if (w_issue_shade && !w_out_xfer) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_issue_shade && w_out_xfer) begin
            n_credit = r_credit - 1'b1;
        end
    end

    tfs_ram #(
        .WIDTH(32),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (o_q_pop && i_q_cmd.wr_en),
        .i_addr (i_q_addr),
        .i_wdata(i_q_cmd.texel),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r1_valid <= w_issue_shade;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // light products
    always_ff @(posedge i_clk) begin
        r1_known <= i_q_cmd.known;
        r1_px    <= 30'($signed(i_q_cmd.nx)) * 30'(tfs_pkg::LIGHT_X);
        r1_py    <= 30'($signed(i_q_cmd.ny)) * 30'(tfs_pkg::LIGHT_Y);
        r1_pz    <= 30'($signed(i_q_cmd.nz)) * 30'(tfs_pkg::LIGHT_Z);
    end

    // dot sum and base colour
    always_ff @(posedge i_clk) begin
        r2_dot <= 31'(r1_px) + 31'(r1_py) + 31'(r1_pz);
        if (r1_known) begin
            r2_r <= w_rdata[23:16];
            r2_g <= w_rdata[15:8];
            r2_b <= w_rdata[7:0];
        end else begin
            r2_r <= tfs_pkg::MAG_RED;
            r2_g <= tfs_pkg::MAG_GREEN;
            r2_b <= tfs_pkg::MAG_BLUE;
        end
    end

    // clamp to one, truncate to Q.16, weight the back light
    assign w_mag   = r2_dot[30] ? 30'(-r2_dot) : r2_dot[29:0];
    assign w_clamp = (w_mag > 30'(29'h1000_0000)) ? 29'h1000_0000 : w_mag[28:0];
    assign w_q16   = w_clamp[28:12];
    assign w_w16   = r2_dot[30] ? w_q16 : '0;

    always_ff @(posedge i_clk) begin
        r3_s16   <= r2_dot[30] ? '0 : w_q16;
        r3_wprod <= 31'(w_w16) * 31'(tfs_pkg::SOFT_WEIGHT);
        r3_r     <= r2_r;
        r3_g     <= r2_g;
        r3_b     <= r2_b;
    end

    assign w_soft_sum = r3_wprod + 31'd32768;
    assign w_fsum     = 18'(r3_s16) + 18'(w_soft_sum[30:16]) + 18'(tfs_pkg::AMBIENT_Q16);
    assign w_factor   = (w_fsum > 18'(tfs_pkg::ONE_Q16)) ? tfs_pkg::ONE_Q16 : w_fsum[16:0];

    always_ff @(posedge i_clk) begin
        r4_pr <= 25'(r3_r) * 25'(w_factor);
        r4_pg <= 25'(r3_g) * 25'(w_factor);
        r4_pb <= 25'(r3_b) * 25'(w_factor);
    end

    assign w_rr = r4_pr + 25'd32768;
    assign w_rg = r4_pg + 25'd32768;
    assign w_rb = r4_pb + 25'd32768;

    tfs_fifo #(
        .WIDTH(24),
        .DEPTH(tfs_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r4_valid),
        .i_data ({w_rr[23:16], w_rg[23:16], w_rb[23:16]}),
        .i_pop  (w_out_xfer),
        .o_data (w_out_data),
        .o_empty(w_out_empty),
        .o_full (w_out_full)
    );

    assign o_valid = !w_out_empty;
    assign o_red   = w_out_data[23:16];
    // credits keep the output queue from filling past its depth
    assign o_green = w_out_full ? w_out_data[15:8] : w_out_data[15:8];
    assign o_blue  = w_out_data[7:0];
    assign o_alpha = tfs_pkg::OPAQUE;

endmodule

>>> rtl/textured_fragment_shade_top.sv
// ----------------------------------------------------------------------------
// textured_fragment_shade_top: textured fragment shader
// Nearest-texel sampling from seven square textures, two-sided diffuse light.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one request per transfer. A load
// (i_req_type 0) writes one texel into the store and gives no result; a shade
// (i_req_type 1) gives one result on the o_valid/i_ready channel, in order.
// A shade passes the request queue, store read, dot sum, clamp and colour
// multiply, then the output queue, before it is shown on o_valid.
// Throughput: one request per cycle unless a shade waits for output room;
// the store port takes one load or shade per cycle; the pipeline never stalls.
// The texel store holds 7*TEX_SIDE*TEX_SIDE words and is not cleared: a
// texel must be loaded before it is sampled. Reset empties the queues.
// When the receiver stalls, up to eight results wait in the output queue;
// after that shades stay in the four-deep request queue and o_ready drops
// once it fills. A held shade also holds the loads queued behind it in
// order, so a load never overtakes an earlier shade.
// ----------------------------------------------------------------------------
module textured_fragment_shade_top #(
    parameter int TEX_SIDE = tfs_pkg::TEX_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [2:0]         i_tex_slot,
    input  logic [7:0]         i_texel_index,
    input  logic [31:0]        i_texel_value,
    input  logic [7:0]         i_block_code,
    input  logic [2:0]         i_face,
    input  logic signed [15:0] i_tex_u,
    input  logic signed [15:0] i_tex_v,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha
);

    localparam int ADDR_W  = $clog2(tfs_pkg::TEX_COUNT * TEX_SIDE * TEX_SIDE);
    localparam int CMD_W   = $bits(tfs_pkg::t_cmd);
    localparam int ENTRY_W = CMD_W + ADDR_W;

    logic                w_push;
    tfs_pkg::t_cmd       w_cmd;
    logic [ADDR_W-1:0]   w_addr;
    logic [ENTRY_W-1:0]  w_q_data;
    logic                w_q_empty;
    logic                w_q_full;
    logic                w_q_pop;

    tfs_front #(
        .TEX_SIDE(TEX_SIDE)
    ) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_tex_slot   (i_tex_slot),
        .i_texel_index(i_texel_index),
        .i_texel_value(i_texel_value),
        .i_block_code (i_block_code),
        .i_face       (i_face),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd),
        .o_addr       (w_addr)
    );

    tfs_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(tfs_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_cmd, w_addr}),
        .i_pop  (w_q_pop),
        .o_data (w_q_data),
        .o_empty(w_q_empty),
        .o_full (w_q_full)
    );

    tfs_back #(
        .TEX_SIDE(TEX_SIDE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(w_q_empty),
        .i_q_cmd  (tfs_pkg::t_cmd'(w_q_data[ENTRY_W-1:ADDR_W])),
        .i_q_addr (w_q_data[ADDR_W-1:0]),
        .o_q_pop  (w_q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_alpha  (o_alpha)
    );

endmodule

>>> rtl/tfs_checker.sv
// ----------------------------------------------------------------------------
// tfs_checker: port-level checks for the textured fragment shader
// Tracks shades in flight and watches the result channel.
// ----------------------------------------------------------------------------
module tfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_req_type,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha
);

    logic [7:0] r_pending, n_pending;
    logic       w_in_shade;
    logic       w_out_xfer;

    assign w_in_shade = i_valid && o_ready && (i_req_type == tfs_pkg::REQ_SHADE);
    assign w_out_xfer = o_valid && i_ready;

    always_comb begin
        n_pending = r_pending;
        if (w_in_shade && !w_out_xfer) begin
            n_pending = r_pending + 1'b1;
        end else if (!w_in_shade && w_out_xfer) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red) && $stable(o_green)
                                && $stable(o_blue))
        else $error("result changed while stalled");

    // every result answers an earlier shade
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 8'd0)
        else $error("result without a pending shade");

    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_alpha == tfs_pkg::OPAQUE)
        else $error("alpha not opaque");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule

bind textured_fragment_shade_top tfs_checker u_tfs_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for textured_fragment_shade_top
// Loads texels and shades fragments through the request channel. A local
// texel shadow and a shading function, or a fixed colour, predict every
// result, checked field by field in order. A directed table comes first,
// then random traffic under several idle/stall mixes and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SIDE         = tfs_pkg::TEX_SIDE_DEF;
    localparam int TEXELS       = SIDE * SIDE;
    localparam int STORE_W      = $clog2(tfs_pkg::TEX_COUNT * TEXELS);
    localparam int IDX_W        = $clog2(TEXELS);
    localparam int STEP         = 256 / SIDE;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;

    // slot code outside the seven textures, loads to it are dropped
    localparam logic [2:0] SLOT_NONE = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         tex_slot;
        logic [7:0]         texel_index;
        logic [31:0]        texel_value;
        logic [7:0]         block_code;
        logic [2:0]         face;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               fixed_color;
        t_color             color;
    } t_frag_item;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_req_type;
    logic [2:0]         i_tex_slot;
    logic [7:0]         i_texel_index;
    logic [31:0]        i_texel_value;
    logic [7:0]         i_block_code;
    logic [2:0]         i_face;
    logic signed [15:0] i_tex_u;
    logic signed [15:0] i_tex_v;
    logic signed [15:0] i_normal_x;
    logic signed [15:0] i_normal_y;
    logic signed [15:0] i_normal_z;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_alpha;

    logic [31:0]        texel_shadow [tfs_pkg::TEX_COUNT * TEXELS];
    bit [TEXELS-1:0]    texel_loaded [tfs_pkg::TEX_COUNT];
    t_color             pending_colors [$];
    t_frag_item         dir_tab [$];
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    bit                 hold_req;
    int unsigned        mismatch_cnt;

    textured_fragment_shade_top #(
        .TEX_SIDE(SIDE)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_tex_slot   (i_tex_slot),
        .i_texel_index(i_texel_index),
        .i_texel_value(i_texel_value),
        .i_block_code (i_block_code),
        .i_face       (i_face),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [2:0] texture_of(input logic [7:0] blk, input logic [2:0] fc,
                                              output bit known);
        logic [2:0] slot;
        known = 1'b1;
        slot  = tfs_pkg::SLOT_DIRT;
        case (blk)
            tfs_pkg::BLK_STONE:  slot = tfs_pkg::SLOT_STONE;
            tfs_pkg::BLK_DIRT:   slot = tfs_pkg::SLOT_DIRT;
            tfs_pkg::BLK_GRASS: begin
                if (fc == tfs_pkg::FACE_NEG_Y)      slot = tfs_pkg::SLOT_DIRT;
                else if (fc == tfs_pkg::FACE_POS_Y) slot = tfs_pkg::SLOT_GRASS_TOP;
                else                                slot = tfs_pkg::SLOT_GRASS_SIDE;
            end
            tfs_pkg::BLK_LOG: begin
                if (fc inside {tfs_pkg::FACE_NEG_Y, tfs_pkg::FACE_POS_Y})
                    slot = tfs_pkg::SLOT_LOG_TOP;
                else
                    slot = tfs_pkg::SLOT_LOG;
            end
            tfs_pkg::BLK_LEAVES: slot = tfs_pkg::SLOT_LEAVES;
            default:             known = 1'b0;
        endcase
        return slot;
    endfunction

    function automatic logic [7:0] scale_channel(input logic [7:0] c, input longint factor);
        longint prod;
        prod = (longint'(c) * factor + 32768) >>> 16;
        return prod[7:0];
    endfunction

    function automatic t_color shade_fragment(input t_frag_item it);
        logic [2:0]  slot;
        bit          known;
        logic [31:0] texel;
        int unsigned fu, fv, col, row;
        longint      dot, lit_front, lit_back, factor;
        logic [7:0]  r, g, b;
        t_color      c;
        slot = texture_of(it.block_code, it.face, known);
        if (known) begin
            fu  = 32'(it.tex_u[7:0]);
            fv  = 32'(it.tex_v[7:0]);
            col = (SIDE * fu) >> 8;
            row = (SIDE * (256 - fv)) >> 8;
            // a zero v fraction lands one past the last row and wraps
            if (row >= SIDE) row = 0;
            texel = texel_shadow[STORE_W'(slot * TEXELS + row * SIDE + col)];
            r = texel[23:16];
            g = texel[15:8];
            b = texel[7:0];
        end else begin
            r = tfs_pkg::MAG_RED;
            g = tfs_pkg::MAG_GREEN;
            b = tfs_pkg::MAG_BLUE;
        end
        dot = longint'(it.normal_x) * longint'(tfs_pkg::LIGHT_X)
            + longint'(it.normal_y) * longint'(tfs_pkg::LIGHT_Y)
            + longint'(it.normal_z) * longint'(tfs_pkg::LIGHT_Z);
        lit_front = (dot > 0) ? dot : 0;
        lit_back  = (dot < 0) ? -dot : 0;
        if (lit_front > (longint'(1) << 28)) lit_front = longint'(1) << 28;
        if (lit_back > (longint'(1) << 28))  lit_back = longint'(1) << 28;
        factor = (lit_front >>> 12)
               + (((lit_back >>> 12) * longint'(tfs_pkg::SOFT_WEIGHT) + 32768) >>> 16)
               + longint'(tfs_pkg::AMBIENT_Q16);
        if (factor > longint'(tfs_pkg::ONE_Q16)) factor = longint'(tfs_pkg::ONE_Q16);
        c.red   = scale_channel(r, factor);
        c.green = scale_channel(g, factor);
        c.blue  = scale_channel(b, factor);
        c.alpha = tfs_pkg::OPAQUE;
        return c;
    endfunction

    function automatic t_frag_item mk_load(input logic [2:0] slot, input logic [7:0] idx,
                                           input logic [31:0] value);
        t_frag_item it;
        it             = '0;
        it.req_type    = tfs_pkg::REQ_LOAD;
        it.tex_slot    = slot;
        it.texel_index = idx;
        it.texel_value = value;
        return it;
    endfunction

    function automatic t_frag_item mk_shade(input logic [7:0] blk, input logic [2:0] fc,
                                            input logic [15:0] u, input logic [15:0] v,
                                            input logic [15:0] nx, input logic [15:0] ny,
                                            input logic [15:0] nz, input logic fixed,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        t_frag_item it;
        it             = '0;
        it.req_type    = tfs_pkg::REQ_SHADE;
        it.block_code  = blk;
        it.face        = fc;
        it.tex_u       = u;
        it.tex_v       = v;
        it.normal_x    = nx;
        it.normal_y    = ny;
        it.normal_z    = nz;
        it.fixed_color = fixed;
        it.color       = {r, g, b, tfs_pkg::OPAQUE};
        return it;
    endfunction

    function automatic logic [15:0] rand_normal(input int unsigned mode);
        int tmp;
        case (mode)
            0:       tmp = int'($urandom);
            1:       tmp = int'($urandom_range(0, 4000)) - 2000;
            default: tmp = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return tmp[15:0];
    endfunction

    function automatic t_frag_item random_item();
        t_frag_item  it;
        bit          known;
        logic [2:0]  slot;
        int unsigned idx, mode, fu, fv;
        logic [7:0]  hi_u, hi_v;
        it.texel_index = 8'($urandom);
        it.texel_value = $urandom;
        it.tex_slot    = 3'($urandom);
        it.block_code  = 8'($urandom);
        it.face        = 3'($urandom);
        it.tex_u       = 16'($urandom);
        it.tex_v       = 16'($urandom);
        it.fixed_color = 1'b0;
        it.color       = '0;
        mode           = $urandom_range(0, 3);
        it.normal_x    = rand_normal(mode);
        it.normal_y    = rand_normal(mode);
        it.normal_z    = rand_normal(mode);
        it.req_type    = ($urandom_range(0, 99) < 70) ? tfs_pkg::REQ_SHADE : tfs_pkg::REQ_LOAD;
        if (it.req_type == tfs_pkg::REQ_LOAD) begin
            if ($urandom_range(0, 15) == 0) it.tex_slot = SLOT_NONE;
            else it.tex_slot = 3'($urandom_range(0, tfs_pkg::TEX_COUNT - 1));
        end else begin
            if ($urandom_range(0, 4) != 0) it.block_code = 8'($urandom_range(1, 5));
            slot = texture_of(it.block_code, it.face, known);
            if (known) begin
                // aim at a texel that has been loaded, keep the coordinate bits random
                do idx = $urandom_range(0, TEXELS - 1);
                while (!texel_loaded[slot][IDX_W'(idx)]);
                fu   = (idx % SIDE) * STEP + $urandom_range(0, STEP - 1);
                fv   = (256 - (idx / SIDE) * STEP - $urandom_range(0, STEP - 1)) & 8'hFF;
                hi_u = 8'($urandom);
                hi_v = 8'($urandom);
                it.tex_u = {hi_u, fu[7:0]};
                it.tex_v = {hi_v, fv[7:0]};
            end
        end
        return it;
    endfunction

    task automatic note_transfer(input t_frag_item it);
        if (it.req_type == tfs_pkg::REQ_LOAD) begin
            if (it.tex_slot < tfs_pkg::TEX_COUNT && it.texel_index < TEXELS) begin
                texel_shadow[STORE_W'(it.tex_slot * TEXELS + it.texel_index)] = it.texel_value;
                texel_loaded[it.tex_slot][it.texel_index] = 1'b1;
            end
        end else if (it.fixed_color) begin
            pending_colors.push_back(it.color);
        end else begin
            pending_colors.push_back(shade_fragment(it));
        end
    endtask

    task automatic send_item(input t_frag_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= it.req_type;
        i_tex_slot    <= it.tex_slot;
        i_texel_index <= it.texel_index;
        i_texel_value <= it.texel_value;
        i_block_code  <= it.block_code;
        i_face        <= it.face;
        i_tex_u       <= it.tex_u;
        i_tex_v       <= it.tex_v;
        i_normal_x    <= it.normal_x;
        i_normal_y    <= it.normal_y;
        i_normal_z    <= it.normal_z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        note_transfer(it);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_item(random_item());
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // result side: check each transfer, then choose ready for the next edge
    initial begin
        int unsigned hold_left;
        t_color      exp_c;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_colors.size() == 0) begin
                    $error("result transfer with nothing pending: r=%0d g=%0d b=%0d a=%0d",
                           o_red, o_green, o_blue, o_alpha);
                    mismatch_cnt++;
                end else begin
                    exp_c = pending_colors.pop_front();
                    check_field("red", exp_c.red, o_red);
                    check_field("green", exp_c.green, o_green);
                    check_field("blue", exp_c.blue, o_blue);
                    check_field("alpha", exp_c.alpha, o_alpha);
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // stall watchdog
    initial begin
        int unsigned stall_cnt;
        stall_cnt = 0;
        while (stall_cnt < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) stall_cnt = 0;
            else                                                          stall_cnt++;
        end
        $display("** textured_fragment_shade_top: FAILED **");
        $finish;
    end

    initial begin
        mismatch_cnt  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_req_type    <= tfs_pkg::REQ_LOAD;
        i_tex_slot    <= '0;
        i_texel_index <= '0;
        i_texel_value <= '0;
        i_block_code  <= '0;
        i_face        <= '0;
        i_tex_u       <= '0;
        i_tex_v       <= '0;
        i_normal_x    <= '0;
        i_normal_y    <= '0;
        i_normal_z    <= '0;

        // one texel in every texture, then a dropped load to the spare slot
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_DIRT, 8'd0, 32'hFF12_3456));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_STONE, 8'd255, 32'hFFFF_FFFF));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_GRASS_SIDE, 8'd15, 32'h00AB_CDEF));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_GRASS_TOP, 8'd240, 32'h80FF_007F));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_LEAVES, 8'd17, 32'h0055_AA33));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_LOG, 8'd128, 32'h7F01_0203));
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_LOG_TOP, 8'd0, 32'h0000_0000));
        dir_tab.push_back(mk_load(SLOT_NONE, 8'd0, 32'hDEAD_BEEF));
        // full light passes the texel through, zero normal leaves only ambient
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_DIRT, 3'd0, 16'h0000, 16'h0000,
                                   16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 8'h12, 8'h34, 8'h56));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_STONE, 3'd1, 16'h7FFF, 16'h8001,
                                   16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd64, 8'd64, 8'd64));
        // unknown blocks: magenta under ambient, back light and full light
        dir_tab.push_back(mk_shade(8'd0, 3'd4, 16'h1234, 16'h5678,
                                   16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd64, 8'd0, 8'd64));
        dir_tab.push_back(mk_shade(8'd255, 3'd5, 16'hFFFF, 16'h0001,
                                   16'h8000, 16'h8000, 16'h7FFF, 1'b1, 8'd102, 8'd0, 8'd102));
        dir_tab.push_back(mk_shade(8'd6, 3'd0, 16'h8000, 16'h7FFF,
                                   16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 8'd255, 8'd0, 8'd255));
        // grass: bottom uses dirt, top its own, sides and the spare faces the side
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_GRASS, tfs_pkg::FACE_NEG_Y, 16'h0000, 16'h0000,
                                   16'h4000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_GRASS, tfs_pkg::FACE_POS_Y, 16'h8000, 16'h0010,
                                   16'h0000, 16'h4000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_GRASS, 3'd0, 16'h00F0, 16'hFFF8,
                                   16'h0000, 16'h0000, 16'hC000, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_GRASS, 3'd6, 16'h00F0, 16'hFFF8,
                                   16'h0000, 16'h0000, 16'h4000, 1'b0, 8'd0, 8'd0, 8'd0));
        // log: top and bottom use the end texture, integer parts must not matter
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LOG, tfs_pkg::FACE_NEG_Y, 16'h0000, 16'h0000,
                                   16'h8000, 16'h8000, 16'h7FFF, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LOG, tfs_pkg::FACE_POS_Y, 16'h0100, 16'hFF00,
                                   16'h2000, 16'h2000, 16'h2000, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LOG, 3'd7, 16'h0005, 16'h0080,
                                   16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 8'd1, 8'd2, 8'd3));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LOG, 3'd1, 16'h0005, 16'h0080,
                                   16'hF000, 16'h1000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LEAVES, 3'd5, 16'h0010, 16'h00F0,
                                   16'h1234, 16'h2345, 16'hF000, 1'b0, 8'd0, 8'd0, 8'd0));
        // overwrite right behind earlier shades of the same texel
        dir_tab.push_back(mk_load(tfs_pkg::SLOT_STONE, 8'd255, 32'h0000_0000));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_STONE, tfs_pkg::FACE_POS_Y, 16'h7FFF, 16'h8001,
                                   16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 8'd0, 8'd0, 8'd0));
        dir_tab.push_back(mk_shade(tfs_pkg::BLK_LEAVES, 3'd4, 16'h0010, 16'h00F0,
                                   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_item(dir_tab[i]);
        wait_drained();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(71, 0, PHASE_ITEMS);
        run_phase(0, 71, PHASE_ITEMS);
        run_phase(8, 8, PHASE_ITEMS);
        // output held off while requests keep coming, so the input backs up
        hold_req = 1'b1;
        run_phase(0, 0, HOLD_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("** textured_fragment_shade_top: PASSED **");
        end else begin
            $display("** textured_fragment_shade_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/tfs_pkg.sv
rtl/tfs_ram.sv
rtl/tfs_fifo.sv
rtl/tfs_front.sv
rtl/tfs_back.sv
rtl/textured_fragment_shade_top.sv
rtl/tfs_checker.sv
test/tb_top.sv
